// ===== hw/rtl/brfp_pkg.sv =====
// Shared operation codes and channel layout for the byte ring FIFO.
`timescale 1ns / 1ps
`default_nettype none

package brfp_pkg;

  // Operation selector carried on in_tuser
  localparam int unsigned FUNC_W = 3;
  localparam logic [FUNC_W-1:0] FUNC_WRITE = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_READ  = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_PEEK  = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_SKIP  = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR = 3'd4;
  localparam logic [FUNC_W-1:0] FUNC_RESET = 3'd5;

  // Field widths
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned OFS_W   = 12;
  localparam int unsigned CNT_W   = 13;
  localparam int unsigned TOTAL_W = 64;

  // Input tdata: data_in, peek_offset, amount, zero fill
  localparam int unsigned IN_BITS = BYTE_W + OFS_W + CNT_W;
  localparam int unsigned IN_TDATA_W = ((IN_BITS + 7) / 8) * 8;

  // Output tdata: data_out, ok, moved, level, total_written, total_read, zero fill
  localparam int unsigned OUT_BITS = BYTE_W + 1 + CNT_W + CNT_W + TOTAL_W + TOTAL_W;
  localparam int unsigned OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

endpackage

`default_nettype wire

// ===== hw/rtl/byte_ring_fifo_with_peek.sv =====
// Byte ring FIFO with peek, skip and clear, built around one synchronous byte memory.
//
//  channel | ports                      | payload
//  --------+----------------------------+------------------------------------------------
//  input   | in_tvalid/in_tready        | tuser: func; tdata: data_in, peek_offset, amount
//  result  | out_tvalid/out_tready      | tdata: data_out, ok, moved, level, totals
//
//  One item per cycle while out_tready holds; out_tvalid rises once the item leaves stage 1.
//  The byte memory is touched at most once per item (write at the tail, read at the head,
//  or peek at head plus offset) on the accept edge; its registered read data joins stage 1.
//  rst_n (synchronous) empties the FIFO and zeroes both totals; memory contents are kept.
//  A stalled result holds in the output register while one more item can finish its
//  access; after that in_tready drops until out_tready returns.
`timescale 1ns / 1ps
`default_nettype none

module byte_ring_fifo_with_peek #(
  parameter int unsigned DEPTH = 4096
) (
  input  wire                                   clk,
  input  wire                                   rst_n,
  input  wire                                   in_tvalid,
  output logic                                  in_tready,
  // [7:0] data_in, [19:8] peek_offset, [32:20] amount
  input  wire  [brfp_pkg::IN_TDATA_W-1:0]       in_tdata,
  // [2:0] func
  input  wire  [brfp_pkg::FUNC_W-1:0]           in_tuser,
  output logic                                  out_tvalid,
  input  wire                                   out_tready,
  // [7:0] data_out, [8] ok, [21:9] moved, [34:22] level,
  // [98:35] total_written, [162:99] total_read
  output logic [brfp_pkg::OUT_TDATA_W-1:0]      out_tdata
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned XW = ((CW > brfp_pkg::CNT_W) ? CW : brfp_pkg::CNT_W) + 1;
  localparam int unsigned TW = brfp_pkg::TOTAL_W;
  localparam int unsigned NW = brfp_pkg::CNT_W;
  localparam int unsigned PAD_W = brfp_pkg::OUT_TDATA_W - brfp_pkg::OUT_BITS;
  localparam logic [XW-1:0] DEPTH_X = XW'(DEPTH);
  localparam logic [AW-1:0] LAST_A  = AW'(DEPTH - 1);

  logic [7:0] mem [DEPTH];
  logic [7:0] mem_q_r;

  logic [AW-1:0] head_r, head_nxt;
  logic [AW-1:0] tail_r, tail_nxt;
  logic [CW-1:0] fill_r, fill_nxt;
  logic [TW-1:0] tw_r, tw_nxt;
  logic [TW-1:0] tr_r, tr_nxt;

  logic          s1_valid_r;
  logic          s1_rd_r, s1_rd_nxt;
  logic          s1_ok_r, s1_ok_nxt;
  logic [NW-1:0] s1_moved_r, s1_moved_nxt;

  logic                               out_valid_r;
  logic [brfp_pkg::OUT_TDATA_W-1:0]   out_data_r;

  logic          s1_move, accept;
  logic [7:0]    data_in;
  logic [XW-1:0] ofs_x, amt_x, fill_x, head_x, peek_sum, skip_n, skip_sum;
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_ra;

  assign s1_move   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_move;
  assign accept    = in_tvalid && in_tready;

  assign data_in = in_tdata[7:0];
  assign ofs_x   = XW'(in_tdata[19:8]);
  assign amt_x   = XW'(in_tdata[32:20]);
  assign fill_x  = XW'(fill_r);
  assign head_x  = XW'(head_r);

  // Wrap head + offset and head + skip count with one subtract each
  always_comb begin
    peek_sum = head_x + ofs_x;
    if (peek_sum >= DEPTH_X) begin
      peek_sum = peek_sum - DEPTH_X;
    end
    skip_n = (amt_x < fill_x) ? amt_x : fill_x;
    skip_sum = head_x + skip_n;
    if (skip_sum >= DEPTH_X) begin
      skip_sum = skip_sum - DEPTH_X;
    end
  end

  always_comb begin
    head_nxt     = head_r;
    tail_nxt     = tail_r;
    fill_nxt     = fill_r;
    tw_nxt       = tw_r;
    tr_nxt       = tr_r;
    s1_rd_nxt    = 1'b0;
    s1_ok_nxt    = 1'b0;
    s1_moved_nxt = '0;
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    mem_ra       = head_r;
    unique case (in_tuser)
      brfp_pkg::FUNC_WRITE: begin
        if (fill_x < DEPTH_X) begin
          mem_we       = accept;
          tail_nxt     = (tail_r == LAST_A) ? '0 : tail_r + AW'(1);
          fill_nxt     = fill_r + CW'(1);
          tw_nxt       = tw_r + TW'(1);
          s1_ok_nxt    = 1'b1;
          s1_moved_nxt = NW'(1);
        end
      end
      brfp_pkg::FUNC_READ: begin
        if (fill_r != '0) begin
          mem_re       = accept;
          head_nxt     = (head_r == LAST_A) ? '0 : head_r + AW'(1);
          fill_nxt     = fill_r - CW'(1);
          tr_nxt       = tr_r + TW'(1);
          s1_rd_nxt    = 1'b1;
          s1_ok_nxt    = 1'b1;
          s1_moved_nxt = NW'(1);
        end
      end
      brfp_pkg::FUNC_PEEK: begin
        if (ofs_x < fill_x) begin
          mem_re       = accept;
          mem_ra       = peek_sum[AW-1:0];
          s1_rd_nxt    = 1'b1;
          s1_ok_nxt    = 1'b1;
          s1_moved_nxt = NW'(1);
        end
      end
      brfp_pkg::FUNC_SKIP: begin
        head_nxt     = skip_sum[AW-1:0];
        fill_nxt     = fill_r - skip_n[CW-1:0];
        tr_nxt       = tr_r + TW'(skip_n);
        s1_ok_nxt    = (skip_n != '0);
        s1_moved_nxt = skip_n[NW-1:0];
      end
      brfp_pkg::FUNC_CLEAR: begin
        head_nxt  = '0;
        tail_nxt  = '0;
        fill_nxt  = '0;
        s1_ok_nxt = 1'b1;
      end
      brfp_pkg::FUNC_RESET: begin
        head_nxt  = '0;
        tail_nxt  = '0;
        fill_nxt  = '0;
        tw_nxt    = '0;
        tr_nxt    = '0;
        s1_ok_nxt = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Byte store: at most one access per accepted item, read data registered
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[tail_r] <= data_in;
    end
    if (mem_re) begin
      mem_q_r <= mem[mem_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      tail_r      <= '0;
      fill_r      <= '0;
      tw_r        <= '0;
      tr_r        <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        head_r <= head_nxt;
        tail_r <= tail_nxt;
        fill_r <= fill_nxt;
        tw_r   <= tw_nxt;
        tr_r   <= tr_nxt;
      end
      if (accept) begin
        s1_valid_r <= 1'b1;
      end else if (s1_move) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_move) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Stage-1 flags; mem_q_r and the state registers stay put until this item moves
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_rd_r    <= s1_rd_nxt;
      s1_ok_r    <= s1_ok_nxt;
      s1_moved_r <= s1_moved_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_data_r <= {{PAD_W{1'b0}}, tr_r, tw_r, fill_x[NW-1:0],
                     s1_moved_r, s1_ok_r, (s1_rd_r ? mem_q_r : 8'd0)};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire

// ===== hw/rtl/brfp_checker.sv =====
// Port-level checker for the byte ring FIFO, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module brfp_checker #(
  parameter int unsigned DEPTH = 4096
) (
  input wire                                 clk,
  input wire                                 rst_n,
  input wire                                 in_tvalid,
  input wire                                 in_tready,
  input wire [brfp_pkg::IN_TDATA_W-1:0]      in_tdata,
  input wire [brfp_pkg::FUNC_W-1:0]          in_tuser,
  input wire                                 out_tvalid,
  input wire                                 out_tready,
  input wire [brfp_pkg::OUT_TDATA_W-1:0]     out_tdata
);

  logic [7:0]  c_data;
  logic        c_ok;
  logic [12:0] c_moved;
  logic [12:0] c_level;

  assign c_data  = out_tdata[7:0];
  assign c_ok    = out_tdata[8];
  assign c_moved = out_tdata[21:9];
  assign c_level = out_tdata[34:22];

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // Level never exceeds the capacity
  a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (DEPTH > 8191) || (32'(c_level) <= DEPTH))
    else $error("level above capacity");

  // A refused item moves nothing and returns zero
  a_refused: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !c_ok |-> c_moved == 13'd0 && c_data == 8'd0)
    else $error("refused item reports data or a count");

  // A returned byte comes from a single successful read or peek
  a_data_one: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && c_data != 8'd0 |-> c_ok && c_moved == 13'd1)
    else $error("data returned without a one-byte move");

endmodule

bind byte_ring_fifo_with_peek brfp_checker #(.DEPTH(DEPTH)) u_brfp_checker (.*);

`default_nettype wire
